@@ rtl/dpb_pkg.sv @@
// Shared types, widths and constants of the density prior box generator.
// Used by every RTL file of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package dpb_pkg;

    // Limits of the dense grid and of the feature map.
    localparam int MAX_DENSITY      = 8;
    localparam int MAX_FEATURE_SIZE = 1024;

    // Field widths of the request and result items.
    localparam int CELL_W = 10;
    localparam int SIZE_W = 24;
    localparam int DENS_W = 4;
    localparam int STEP_W = 24;
    localparam int OFFS_W = 8;
    localparam int INV_W  = 24;
    localparam int EDGE_W = 19;

    // Stream and configuration bus widths.
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 80;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Average step in whole pixels: (step_x + step_y) >> 9.
    localparam int AVG_SHIFT = 9;
    localparam int AVG_W     = STEP_W + 1 - AVG_SHIFT;
    localparam int DIV_CNT_W = $clog2(AVG_W);

    // Cell centre arithmetic in Q.16 pixels.
    localparam int POS_W       = CELL_W + OFFS_W;
    localparam int PROD_W      = POS_W + STEP_W;
    localparam int CTR_W       = PROD_W + 2;
    localparam int HALF_SHIFT  = 7;
    localparam int HALF_W      = SIZE_W + HALF_SHIFT;
    localparam int GRID_SHIFT  = 15;
    localparam int PITCH_SHIFT = 16;

    // Normalization datapath.
    localparam int VAL_W       = CTR_W + 1;
    localparam int MAG_W       = CTR_W;
    localparam int LO_W        = 20;
    localparam int HI_W        = MAG_W - LO_W;
    localparam int PH_W        = HI_W + INV_W;
    localparam int PL_W        = LO_W + INV_W;
    localparam int SUM_W       = PH_W + LO_W;
    localparam int FRAC_SHIFT  = 24;
    localparam int Q_W         = SUM_W - FRAC_SHIFT;
    localparam int ROUND_BIAS  = 1 << (FRAC_SHIFT - 1);
    localparam int EDGE_POS_MAX = 262143;
    localparam int EDGE_NEG_MAX = 262144;
    localparam int ONE_Q16      = 65536;

    // Grid position counters.
    localparam int IDX_W = (MAX_DENSITY > 1) ? $clog2(MAX_DENSITY) : 1;

    // Request queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Register reset values.
    localparam logic [STEP_W-1:0] STEP_X_RST  = STEP_W'(2048);
    localparam logic [STEP_W-1:0] STEP_Y_RST  = STEP_W'(2048);
    localparam logic [OFFS_W-1:0] OFFSET_RST  = OFFS_W'(128);
    localparam logic [INV_W-1:0]  INV_W_RST   = INV_W'(65536);
    localparam logic [INV_W-1:0]  INV_H_RST   = INV_W'(65536);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_X        = 3'd0,
        CFG_STEP_Y        = 3'd1,
        CFG_CENTER_OFFSET = 3'd2,
        CFG_INV_WIDTH     = 3'd3,
        CFG_INV_HEIGHT    = 3'd4,
        CFG_CLIP_ENABLE   = 3'd5
    } cfg_index_t;

    // Configuration register file contents.
    typedef struct packed {
        logic [STEP_W-1:0] step_x;
        logic [STEP_W-1:0] step_y;
        logic [OFFS_W-1:0] center_offset;
        logic [INV_W-1:0]  inv_image_width;
        logic [INV_W-1:0]  inv_image_height;
        logic              clip_enable;
    } cfg_t;

    // One prepared request handed from front to back.
    typedef struct packed {
        logic signed [CTR_W-1:0] start_x;
        logic signed [CTR_W-1:0] start_y;
        logic [HALF_W-1:0]       half_w;
        logic [HALF_W-1:0]       half_h;
        logic [AVG_W-1:0]        shift;
        logic [DENS_W-1:0]       density;
    } job_t;

    // Control of one normalization lane.
    typedef struct packed {
        logic advance;
        logic max_edge;
        logic clip;
    } norm_ctrl_t;

    // Front sequencer states.
    typedef enum logic [1:0] {
        FRONT_IDLE,
        FRONT_DIV,
        FRONT_PUSH
    } front_state_t;

endpackage

`default_nettype wire

@@ rtl/dpb_front.sv @@
// Front part: accepts requests, saturates fields, divides the average step by
// the density and forms the first grid centre. Depends on dpb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dpb_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  dpb_pkg::cfg_t                    cfg,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [dpb_pkg::IN_DATA_W-1:0]    s_tdata,
    output logic                             q_push,
    output dpb_pkg::job_t                    q_data,
    input  logic                             q_full
);
    import dpb_pkg::*;

    localparam int COL_LSB  = 0;
    localparam int ROW_LSB  = CELL_W;
    localparam int BW_LSB   = 2 * CELL_W;
    localparam int BH_LSB   = BW_LSB + SIZE_W;
    localparam int DENS_LSB = BH_LSB + SIZE_W;

    front_state_t state_reg, state_next;

    logic [CELL_W-1:0]  in_col, in_row, col_sat, row_sat;
    logic [SIZE_W-1:0]  in_bw, in_bh;
    logic [DENS_W-1:0]  in_dens, dens_sat;
    logic [STEP_W:0]    step_sum;
    logic               accept;

    logic [POS_W-1:0]        pos_x_reg, pos_y_reg;
    logic [HALF_W-1:0]       half_w_reg, half_h_reg;
    logic [DENS_W-1:0]       dens_reg;
    logic [AVG_W-1:0]        avg_reg, quo_reg;
    logic [DENS_W-1:0]       rem_reg;
    logic [DIV_CNT_W-1:0]    cnt_reg;
    logic [PROD_W-1:0]       prod_x_reg, prod_y_reg;
    logic signed [CTR_W-1:0] base_x_reg, base_y_reg;

    logic [DENS_W:0]         trial;
    logic                    quo_bit;
    logic [DENS_W-1:0]       rem_next;
    logic signed [CTR_W-1:0] avg_term, shift_term;

    // Field extraction and saturation.
    always_comb
    begin
        in_col   = s_tdata[COL_LSB +: CELL_W];
        in_row   = s_tdata[ROW_LSB +: CELL_W];
        in_bw    = s_tdata[BW_LSB +: SIZE_W];
        in_bh    = s_tdata[BH_LSB +: SIZE_W];
        in_dens  = s_tdata[DENS_LSB +: DENS_W];
        col_sat  = (32'(in_col) >= MAX_FEATURE_SIZE) ? CELL_W'(MAX_FEATURE_SIZE - 1) : in_col;
        row_sat  = (32'(in_row) >= MAX_FEATURE_SIZE) ? CELL_W'(MAX_FEATURE_SIZE - 1) : in_row;
        dens_sat = (in_dens > DENS_W'(MAX_DENSITY)) ? DENS_W'(MAX_DENSITY) : in_dens;
        step_sum = {1'b0, cfg.step_x} + {1'b0, cfg.step_y};
        accept   = s_tvalid && s_tready;
    end

    // One restoring division step per cycle.
    always_comb
    begin
        trial    = {rem_reg, quo_reg[AVG_W-1]};
        quo_bit  = (trial >= {1'b0, dens_reg});
        rem_next = quo_bit ? DENS_W'(trial - {1'b0, dens_reg}) : DENS_W'(trial);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FRONT_IDLE:
            begin
                if (s_tvalid && (in_dens != '0))
                begin
                    state_next = FRONT_DIV;
                end
            end
            FRONT_DIV:
            begin
                if (cnt_reg == DIV_CNT_W'(AVG_W - 1))
                begin
                    state_next = FRONT_PUSH;
                end
            end
            FRONT_PUSH:
            begin
                if (!q_full)
                begin
                    state_next = FRONT_IDLE;
                end
            end
            default:
            begin
                state_next = FRONT_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer.
    always_comb
    begin
        s_tready = 1'b0;
        q_push   = 1'b0;
        case (state_reg)
            FRONT_IDLE: s_tready = 1'b1;
            FRONT_PUSH: q_push   = !q_full;
            default:    ;
        endcase
    end

    // Prepared request: the first centre adds half a grid shift to the base.
    always_comb
    begin
        shift_term     = CTR_W'({quo_reg, {GRID_SHIFT{1'b0}}});
        q_data.start_x = base_x_reg + shift_term;
        q_data.start_y = base_y_reg + shift_term;
        q_data.half_w  = half_w_reg;
        q_data.half_h  = half_h_reg;
        q_data.shift   = quo_reg;
        q_data.density = dens_reg;
    end

    always_comb
    begin
        avg_term = CTR_W'({avg_reg, {GRID_SHIFT{1'b0}}});
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FRONT_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == FRONT_DIV)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else
            begin
                cnt_reg <= '0;
            end
        end
    end

    // Request capture, divider and centre products.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pos_x_reg  <= {col_sat, cfg.center_offset};
            pos_y_reg  <= {row_sat, cfg.center_offset};
            half_w_reg <= {in_bw, {HALF_SHIFT{1'b0}}};
            half_h_reg <= {in_bh, {HALF_SHIFT{1'b0}}};
            dens_reg   <= dens_sat;
            avg_reg    <= step_sum[STEP_W:AVG_SHIFT];
            quo_reg    <= step_sum[STEP_W:AVG_SHIFT];
            rem_reg    <= '0;
        end
        else if (state_reg == FRONT_DIV)
        begin
            // Operands hold still while dividing, so the products settle early.
            rem_reg    <= rem_next;
            quo_reg    <= {quo_reg[AVG_W-2:0], quo_bit};
            prod_x_reg <= pos_x_reg * cfg.step_x;
            prod_y_reg <= pos_y_reg * cfg.step_y;
            base_x_reg <= signed'(CTR_W'(prod_x_reg)) - avg_term;
            base_y_reg <= signed'(CTR_W'(prod_y_reg)) - avg_term;
        end
    end

endmodule

`default_nettype wire

@@ rtl/dpb_queue.sv @@
// Short request queue between the front and back parts, in flip-flops.
// Depends on dpb_pkg for the entry type and depth.
`timescale 1ns / 1ps
`default_nettype none

module dpb_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  dpb_pkg::job_t push_data,
    output logic          full,
    input  logic          pop,
    output dpb_pkg::job_t pop_data,
    output logic          empty
);
    import dpb_pkg::*;

    job_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    always_comb
    begin
        full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
        empty    = (count_reg == '0);
        pop_data = entry_reg[rd_ptr_reg];
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/dpb_norm.sv @@
// One normalization lane: centre +/- half size, times a Q0.24 reciprocal,
// rounded to Q.16 and saturated per edge kind. Depends on dpb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dpb_norm (
    input  logic                                clk,
    input  dpb_pkg::norm_ctrl_t                 ctrl,
    input  logic signed [dpb_pkg::CTR_W-1:0]    centre,
    input  logic [dpb_pkg::HALF_W-1:0]          half,
    input  logic [dpb_pkg::INV_W-1:0]           inv,
    output logic [dpb_pkg::EDGE_W-1:0]          coord
);
    import dpb_pkg::*;

    logic signed [VAL_W-1:0] val_next, val_reg;
    logic                    neg_reg, neg3_reg;
    logic [MAG_W-1:0]        mag_reg;
    logic [PH_W-1:0]         ph_reg;
    logic [PL_W-1:0]         pl_reg;
    logic [SUM_W-1:0]        sum;
    logic [Q_W-1:0]          q;
    logic [EDGE_W-1:0]       pos_sat, neg_mag, one_cap, coord_next;

    // Edge position in Q.16 pixels.
    always_comb
    begin
        if (ctrl.max_edge)
        begin
            val_next = VAL_W'(centre) + signed'(VAL_W'(half));
        end
        else
        begin
            val_next = VAL_W'(centre) - signed'(VAL_W'(half));
        end
    end

    // Rounded product and the saturation of each edge kind.
    always_comb
    begin
        sum     = {ph_reg, {LO_W{1'b0}}} + SUM_W'(pl_reg) + SUM_W'(ROUND_BIAS);
        q       = sum[SUM_W-1:FRAC_SHIFT];
        pos_sat = (q > Q_W'(EDGE_POS_MAX)) ? EDGE_W'(EDGE_POS_MAX) : q[EDGE_W-1:0];
        neg_mag = (q > Q_W'(EDGE_NEG_MAX)) ? EDGE_W'(EDGE_NEG_MAX) : q[EDGE_W-1:0];
        one_cap = (q > Q_W'(ONE_Q16)) ? EDGE_W'(ONE_Q16) : q[EDGE_W-1:0];

        if (!ctrl.max_edge)
        begin
            // Lower edges are floored at zero.
            if (neg3_reg)
            begin
                coord_next = '0;
            end
            else
            begin
                coord_next = ctrl.clip ? one_cap : pos_sat;
            end
        end
        else
        begin
            // Upper edges are capped at one.
            if (neg3_reg)
            begin
                coord_next = ctrl.clip ? '0 : EDGE_W'(-neg_mag);
            end
            else
            begin
                coord_next = one_cap;
            end
        end
    end

    // Four stages: add, magnitude, partial products, round and saturate.
    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            val_reg  <= val_next;
            neg_reg  <= val_reg[VAL_W-1];
            mag_reg  <= val_reg[VAL_W-1] ? MAG_W'(-val_reg) : MAG_W'(val_reg);
            neg3_reg <= neg_reg;
            ph_reg   <= mag_reg[MAG_W-1:LO_W] * inv;
            pl_reg   <= mag_reg[LO_W-1:0] * inv;
            coord    <= coord_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/dpb_back.sv @@
// Back: walks a request's dense grid, one box per cycle unless stalled, through
// four normalization lanes into the output register. Depends on dpb_pkg, dpb_norm.
`timescale 1ns / 1ps
`default_nettype none

module dpb_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  dpb_pkg::cfg_t                    cfg,
    input  logic                             q_empty,
    input  dpb_pkg::job_t                    q_data,
    output logic                             q_pop,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [dpb_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic                             m_tlast
);
    import dpb_pkg::*;

    localparam int PAD_W = OUT_DATA_W - 4 * EDGE_W;

    logic                    busy_reg;
    logic [IDX_W-1:0]        di_reg, dj_reg, last_idx_reg;
    logic signed [CTR_W-1:0] start_x_reg, cx_reg, cy_reg;
    logic [HALF_W-1:0]       half_w_reg, half_h_reg;
    logic [AVG_W-1:0]        shift_reg;
    logic signed [CTR_W-1:0] pitch;

    logic       s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    logic       s1_last_reg, s2_last_reg, s3_last_reg, out_last_reg;
    logic       advance, issue_last, row_end;

    norm_ctrl_t min_ctrl, max_ctrl;
    logic [EDGE_W-1:0] x_min, y_min, x_max, y_max;

    // Whole pipeline moves unless the output register holds an untaken box.
    always_comb
    begin
        advance    = !out_valid_reg || m_tready;
        q_pop      = !busy_reg && !q_empty;
        row_end    = (dj_reg == last_idx_reg);
        issue_last = row_end && (di_reg == last_idx_reg);
        pitch      = CTR_W'({shift_reg, {PITCH_SHIFT{1'b0}}});

        min_ctrl.advance  = advance;
        min_ctrl.max_edge = 1'b0;
        min_ctrl.clip     = cfg.clip_enable;
        max_ctrl.advance  = advance;
        max_ctrl.max_edge = 1'b1;
        max_ctrl.clip     = cfg.clip_enable;

        m_tvalid = out_valid_reg;
        m_tlast  = out_last_reg;
        m_tdata  = {{PAD_W{1'b0}}, y_max, x_max, y_min, x_min};
    end

    // Grid walk and pipeline valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            di_reg        <= '0;
            dj_reg        <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                busy_reg <= 1'b1;
                di_reg   <= '0;
                dj_reg   <= '0;
            end
            else if (advance && busy_reg)
            begin
                if (row_end)
                begin
                    dj_reg <= '0;
                    di_reg <= di_reg + 1'b1;
                    if (issue_last)
                    begin
                        busy_reg <= 1'b0;
                    end
                end
                else
                begin
                    dj_reg <= dj_reg + 1'b1;
                end
            end
            if (advance)
            begin
                s1_valid_reg  <= busy_reg;
                s2_valid_reg  <= s1_valid_reg;
                s3_valid_reg  <= s2_valid_reg;
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    // Request fields, current centres and last-box marks.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            start_x_reg  <= q_data.start_x;
            cx_reg       <= q_data.start_x;
            cy_reg       <= q_data.start_y;
            half_w_reg   <= q_data.half_w;
            half_h_reg   <= q_data.half_h;
            shift_reg    <= q_data.shift;
            last_idx_reg <= IDX_W'(q_data.density - 1'b1);
        end
        else if (advance && busy_reg)
        begin
            if (row_end)
            begin
                cx_reg <= start_x_reg;
                cy_reg <= cy_reg + pitch;
            end
            else
            begin
                cx_reg <= cx_reg + pitch;
            end
        end
        if (advance)
        begin
            s1_last_reg  <= issue_last;
            s2_last_reg  <= s1_last_reg;
            s3_last_reg  <= s2_last_reg;
            out_last_reg <= s3_last_reg;
        end
    end

    // Edges x_min, y_min, x_max and y_max of the current box.
    dpb_norm u_x_min (
        .clk    (clk),
        .ctrl   (min_ctrl),
        .centre (cx_reg),
        .half   (half_w_reg),
        .inv    (cfg.inv_image_width),
        .coord  (x_min)
    );

    dpb_norm u_y_min (
        .clk    (clk),
        .ctrl   (min_ctrl),
        .centre (cy_reg),
        .half   (half_h_reg),
        .inv    (cfg.inv_image_height),
        .coord  (y_min)
    );

    dpb_norm u_x_max (
        .clk    (clk),
        .ctrl   (max_ctrl),
        .centre (cx_reg),
        .half   (half_w_reg),
        .inv    (cfg.inv_image_width),
        .coord  (x_max)
    );

    dpb_norm u_y_max (
        .clk    (clk),
        .ctrl   (max_ctrl),
        .centre (cy_reg),
        .half   (half_h_reg),
        .inv    (cfg.inv_image_height),
        .coord  (y_max)
    );

endmodule

`default_nettype wire

@@ rtl/density_prior_box_generator.sv @@
// Density prior box generator, top level: configuration registers, front part,
// request queue and back part. Depends on dpb_pkg, dpb_front, dpb_queue, dpb_back.
//
// Usage: each request on the s_ stream names one feature cell, a box size and a
// density n (above 8 taken as 8); the block returns n*n normalized boxes on the m_
// stream, row by row, with m_tlast on the final box. A request of density zero is
// taken and yields nothing. Registers must be written over the cfg_ channel (always
// ready) only while the block is idle; the block itself does not enforce this.
// Timing: the front takes one request at a time (capture, 16 divide steps by
// the density, one hand-off into a two-entry queue). The back emits one box a
// cycle while the receiver does not stall, through a four-stage normalization
// pipeline, and pops the next request only after issuing the last box of the
// current one.
// Reset clears all control state and loads the register reset values; no
// clearing pass is needed. When the receiver stalls, the whole back pipeline
// holds, the queue fills, and then s_tready stays low after the current request.
`timescale 1ns / 1ps
`default_nettype none

module density_prior_box_generator (
    input  logic                             clk,
    input  logic                             rst_n,
    // Configuration write channel.
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [dpb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dpb_pkg::CFG_DATA_W-1:0]   cfg_data,
    // Request stream.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // cell_col[9:0], cell_row[19:10], box_width[43:20], box_height[67:44], density[71:68]
    input  logic [dpb_pkg::IN_DATA_W-1:0]    s_tdata,
    // Box stream.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // x_min[18:0], y_min[37:19], x_max[56:38], y_max[75:57], zero[79:76]
    output logic [dpb_pkg::OUT_DATA_W-1:0]   m_tdata,
    // last_box
    output logic                             m_tlast
);
    import dpb_pkg::*;

    cfg_t cfg_reg, cfg_next;

    logic q_push, q_full, q_pop, q_empty;
    job_t q_wr_data, q_rd_data;

    // Register writes; indexes past the list are ignored.
    always_comb
    begin
        cfg_ready = 1'b1;
        cfg_next  = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_STEP_X:        cfg_next.step_x           = cfg_data[STEP_W-1:0];
                CFG_STEP_Y:        cfg_next.step_y           = cfg_data[STEP_W-1:0];
                CFG_CENTER_OFFSET: cfg_next.center_offset    = cfg_data[OFFS_W-1:0];
                CFG_INV_WIDTH:     cfg_next.inv_image_width  = cfg_data[INV_W-1:0];
                CFG_INV_HEIGHT:    cfg_next.inv_image_height = cfg_data[INV_W-1:0];
                CFG_CLIP_ENABLE:   cfg_next.clip_enable      = cfg_data[0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_x           <= STEP_X_RST;
            cfg_reg.step_y           <= STEP_Y_RST;
            cfg_reg.center_offset    <= OFFSET_RST;
            cfg_reg.inv_image_width  <= INV_W_RST;
            cfg_reg.inv_image_height <= INV_H_RST;
            cfg_reg.clip_enable      <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Request intake and grid setup.
    dpb_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_push   (q_push),
        .q_data   (q_wr_data),
        .q_full   (q_full)
    );

    // Decoupling queue.
    dpb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wr_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_rd_data),
        .empty     (q_empty)
    );

    // Box generation.
    dpb_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_empty  (q_empty),
        .q_data   (q_rd_data),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire
